// File: design/lrupr_pkg.sv
package lrupr_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_FRAMES = 8;
    localparam int DEF_PAGE_BITS  = 16;

    // frame count register and fault counter widths
    localparam int CFG_W   = 4;
    localparam int FAULT_W = 32;

    // frame count after reset
    localparam logic [CFG_W-1:0] NUM_FRAMES_RST = CFG_W'(8);

    // command from the sequencer to the recency file
    typedef struct packed {
        logic clear;    // empty all frames
        logic touch;    // make the given frame most recent and mark it valid
        logic age_all;  // touch ages every valid frame (fill of an empty frame)
    } t_rank_cmd;

endpackage

// File: design/lrupr_ram.sv
module lrupr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/lrupr_rank.sv
module lrupr_rank #(
    parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrupr_pkg::t_rank_cmd          i_cmd,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_slot,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_limit,
    output logic [MAX_FRAMES-1:0]         o_valid,
    output logic [$clog2(MAX_FRAMES)-1:0] o_rank [MAX_FRAMES]
);
    import lrupr_pkg::*;

    localparam int RANK_W = $clog2(MAX_FRAMES);

    logic [MAX_FRAMES-1:0] r_valid;
    logic [RANK_W-1:0]     r_rank [MAX_FRAMES];

    // valid bits and ages; touched frame goes to age 0, valid frames younger than the limit (all on age_all) age by one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.touch) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                if (i_slot == RANK_W'(i)) begin
                    r_rank[i]  <= '0;
                    r_valid[i] <= 1'b1;
                end else if (r_valid[i] && (i_cmd.age_all || r_rank[i] < i_limit)) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rank  = r_rank;

endmodule

// File: design/lru_page_replacement.sv
// LRU page replacement over up to MAX_FRAMES fully associative page frames. Each input beat
// carries one page reference; each reference gives one result beat with hit/fault, the frame
// now holding the page, the evicted page (zero when nothing was evicted) and the saturating
// fault total. A miss searches all N frames, N being the active frame count; a hit in frame k
// ends the search there. The frame search walks the page store one frame per cycle through its
// single read port and one comparator; then the update state, once the output register is free,
// updates ages, store and counter. The result sits in an output register, so the search of the
// next reference may start while it waits. Writing the frame count (0 acts as 1, values above
// MAX_FRAMES as MAX_FRAMES) is accepted while no reference is in flight and empties all frames;
// the fault total is kept.
module lru_page_replacement #(
    parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lrupr_pkg::DEF_PAGE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // frame count register
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]   i_cfg_data,
    // page references
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [PAGE_BITS-1:0]          i_page,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [$clog2(MAX_FRAMES)-1:0] o_slot,
    output logic                          o_evicted_valid,
    output logic [PAGE_BITS-1:0]          o_evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0] o_fault_count
);
    import lrupr_pkg::*;

    localparam int SLOT_W = $clog2(MAX_FRAMES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE
    } t_state;

    // last active frame index for a frame count value
    function automatic logic [SLOT_W-1:0] last_frame(input logic [CFG_W-1:0] v);
        logic [SLOT_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) > MAX_FRAMES) begin
            res = SLOT_W'(MAX_FRAMES - 1);
        end else begin
            res = SLOT_W'(v - 1'b1);
        end
        return res;
    endfunction

    t_state              r_state;
    logic [SLOT_W-1:0]   r_last;
    logic [SLOT_W-1:0]   r_idx;
    logic [PAGE_BITS-1:0] r_page;
    logic                r_hit;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   r_limit;
    logic                r_empty_found;
    logic [SLOT_W-1:0]   r_empty_idx;
    logic [SLOT_W-1:0]   r_old_rank;
    logic [SLOT_W-1:0]   r_old_idx;
    logic [PAGE_BITS-1:0] r_old_page;
    logic [FAULT_W-1:0]  r_fault;

    logic                r_out_valid;
    logic                r_out_hit;
    logic [SLOT_W-1:0]   r_out_slot;
    logic                r_out_evv;
    logic [PAGE_BITS-1:0] r_out_evp;
    logic [FAULT_W-1:0]  r_out_fault;

    logic                in_acc;
    logic                cfg_acc;
    logic                out_free;
    logic                upd;
    logic                cur_valid;
    logic [SLOT_W-1:0]   cur_rank;
    logic                cur_match;
    logic                at_last;
    logic                fill_empty;
    logic [SLOT_W-1:0]   upd_slot;
    logic [FAULT_W-1:0]  n_fault;
    logic [PAGE_BITS-1:0] rd_data;
    logic [SLOT_W-1:0]   rd_addr;
    logic [MAX_FRAMES-1:0] frame_valid;
    logic [SLOT_W-1:0]   frame_rank [MAX_FRAMES];
    t_rank_cmd           rank_cmd;
    logic [SLOT_W-1:0]   rank_limit;

    // handshakes
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign upd         = (r_state == S_UPDATE) && out_free;

    // frame under test this search cycle
    assign cur_valid = frame_valid[r_idx];
    assign cur_rank  = frame_rank[r_idx];
    assign cur_match = cur_valid && (rd_data == r_page);
    assign at_last   = (r_idx == r_last);

    // outcome of a finished search
    assign fill_empty = !r_hit && r_empty_found;
    assign upd_slot   = r_hit ? r_slot : (r_empty_found ? r_empty_idx : r_old_idx);
    assign n_fault    = (!r_hit && r_fault != '1) ? r_fault + 1'b1 : r_fault;
    assign rank_limit = r_hit ? r_limit : r_old_rank;

    assign rank_cmd.clear   = cfg_acc;
    assign rank_cmd.touch   = upd;
    assign rank_cmd.age_all = fill_empty;

    // read ahead: the next frame's page arrives when its search cycle starts
    assign rd_addr = (r_state == S_SEARCH && !at_last) ? r_idx + 1'b1 : '0;

    lrupr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (upd && !r_hit),
        .i_waddr (upd_slot),
        .i_wdata (r_page),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    lrupr_rank #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rank_cmd),
        .i_slot  (upd_slot),
        .i_limit (rank_limit),
        .o_valid (frame_valid),
        .o_rank  (frame_rank)
    );

    // sequencer, search trackers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= last_frame(NUM_FRAMES_RST);
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        r_last <= last_frame(i_cfg_data);
                    end else if (in_acc) begin
                        r_page        <= i_page;
                        r_idx         <= '0;
                        r_hit         <= 1'b0;
                        r_empty_found <= 1'b0;
                        r_state       <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (cur_match) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_idx;
                        r_limit <= cur_rank;
                        r_state <= S_UPDATE;
                    end else begin
                        // lowest empty frame
                        if (!cur_valid && !r_empty_found) begin
                            r_empty_found <= 1'b1;
                            r_empty_idx   <= r_idx;
                        end
                        // oldest frame, lowest index on a tie
                        if (r_idx == '0 || cur_rank > r_old_rank) begin
                            r_old_rank <= cur_rank;
                            r_old_idx  <= r_idx;
                            r_old_page <= rd_data;
                        end
                        if (at_last) begin
                            r_state <= S_UPDATE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_UPDATE: begin
                    if (out_free) begin
                        r_fault     <= n_fault;
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit;
                        r_out_slot  <= upd_slot;
                        r_out_evv   <= !r_hit && !r_empty_found;
                        r_out_evp   <= (!r_hit && !r_empty_found) ? r_old_page : '0;
                        r_out_fault <= n_fault;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_slot          = r_out_slot;
    assign o_evicted_valid = r_out_evv;
    assign o_evicted_page  = r_out_evp;
    assign o_fault_count   = r_out_fault;

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted_valid))
        else $error("hit result reports an eviction");

    // fault total never goes down
    a_fault_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> r_fault >= $past(r_fault))
        else $error("fault total decreased");

    // resident frames never exceed the active frame count
    a_valid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(frame_valid) <= int'(r_last) + 1)
        else $error("more valid frames than active frames");

endmodule

// File: tb/tb_lru_page_replacement.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement;

    import lrupr_pkg::*;

    localparam int NFR   = 8;
    localparam int PG_W  = 16;
    localparam int SLT_W = $clog2(NFR);
    localparam int HOLD_CYCLES = 300;

    // one expected result beat
    typedef struct packed {
        logic              hit;
        logic [SLT_W-1:0]  slot;
        logic              ev_valid;
        logic [PG_W-1:0]   ev_page;
        logic [FAULT_W-1:0] faults;
    } t_lru_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [PG_W-1:0]    i_page = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_hit;
    logic [SLT_W-1:0]   o_slot;
    logic               o_evicted_valid;
    logic [PG_W-1:0]    o_evicted_page;
    logic [FAULT_W-1:0] o_fault_count;

    lru_page_replacement #(
        .MAX_FRAMES (NFR),
        .PAGE_BITS  (PG_W)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_page          (i_page),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // references waiting to be sent, results waiting to arrive
    logic [PG_W-1:0] page_q[$];
    t_lru_result     result_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_go = 1'b0;
    int hold_left = 0;

    int n_errors  = 0;
    int n_checked = 0;
    int n_hits    = 0;
    int n_evicts  = 0;
    int n_fills   = 0;
    int n_cfg     = 0;

    // shadow of the frame set
    logic [PG_W-1:0]    frm_page[NFR];
    logic               frm_valid[NFR];
    logic [SLT_W-1:0]   frm_age[NFR];
    logic [FAULT_W-1:0] fault_tot;
    logic [CFG_W-1:0]   frame_cfg;
    t_lru_result        next_res;

    function automatic void clear_frames();
        for (int i = 0; i < NFR; i++) begin
            frm_page[i]  = '0;
            frm_valid[i] = 1'b0;
            frm_age[i]   = '0;
        end
    endfunction

    function automatic int active_frames(logic [CFG_W-1:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > NFR)
            return NFR;
        return int'(cfg);
    endfunction

    // frame f becomes most recent; valid frames younger than limit get one older
    function automatic void age_frames(int n, int f, int limit);
        for (int i = 0; i < n; i++)
            if (i != f && frm_valid[i] && int'(frm_age[i]) < limit)
                frm_age[i] = frm_age[i] + 1'b1;
        frm_age[f] = '0;
    endfunction

    // look up one page reference, update the shadow, return the expected beat
    function automatic t_lru_result lru_lookup(logic [PG_W-1:0] pg);
        t_lru_result r;
        int n;
        int s;
        int oldest;
        logic found;
        n = active_frames(frame_cfg);
        r = '0;
        s = 0;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!r.hit && frm_valid[i] && frm_page[i] == pg) begin
                r.hit = 1'b1;
                s = i;
            end
        end
        if (r.hit) begin
            age_frames(n, s, int'(frm_age[s]));
        end else begin
            for (int i = 0; i < n; i++) begin
                if (!found && !frm_valid[i]) begin
                    found = 1'b1;
                    s = i;
                end
            end
            if (!found) begin
                // no empty frame: replace the oldest
                oldest = 0;
                s = 0;
                for (int i = 0; i < n; i++) begin
                    if (int'(frm_age[i]) > oldest) begin
                        oldest = int'(frm_age[i]);
                        s = i;
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page  = frm_page[s];
                age_frames(n, s, int'(frm_age[s]));
            end else begin
                age_frames(n, s, 256);
            end
            frm_page[s]  = pg;
            frm_valid[s] = 1'b1;
            if (fault_tot != '1)
                fault_tot = fault_tot + 1'b1;
        end
        r.slot   = SLT_W'(s);
        r.faults = fault_tot;
        return r;
    endfunction

    // reference driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (page_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_page     <= page_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        i_out_stall <= (hold_go || hold_left > 1) ? 1'b1
                                                  : ($urandom_range(99) < recv_idle_pct);
    end

    // monitor: check result beats, predict accepted references, track config writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frames();
            fault_tot = '0;
            frame_cfg = NUM_FRAMES_RST;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result beat hit=%0b slot=%0d", $time, o_hit,
                             o_slot);
                    n_errors++;
                end else begin
                    next_res = result_q.pop_front();
                    n_checked++;
                    if (o_hit !== next_res.hit) begin
                        $display("%0t: hit exp %0b got %0b", $time, next_res.hit, o_hit);
                        n_errors++;
                    end
                    if (o_slot !== next_res.slot) begin
                        $display("%0t: slot exp %0d got %0d", $time, next_res.slot, o_slot);
                        n_errors++;
                    end
                    if (o_evicted_valid !== next_res.ev_valid) begin
                        $display("%0t: evicted_valid exp %0b got %0b", $time,
                                 next_res.ev_valid, o_evicted_valid);
                        n_errors++;
                    end
                    if (o_evicted_page !== next_res.ev_page) begin
                        $display("%0t: evicted_page exp %h got %h", $time, next_res.ev_page,
                                 o_evicted_page);
                        n_errors++;
                    end
                    if (o_fault_count !== next_res.faults) begin
                        $display("%0t: fault_count exp %0d got %0d", $time, next_res.faults,
                                 o_fault_count);
                        n_errors++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                frame_cfg = i_cfg_data;
                clear_frames();
                n_cfg++;
            end
            if (i_in_valid && !o_in_stall) begin
                next_res = lru_lookup(i_page);
                result_q.push_back(next_res);
                if (next_res.hit)
                    n_hits++;
                else if (next_res.ev_valid)
                    n_evicts++;
                else
                    n_fills++;
            end
        end
    end

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do @(negedge i_clk);
        while (page_q.size() != 0 || i_in_valid || result_q.size() != 0);
    endtask

    task automatic write_frames(logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly a small working set around base so hits and evictions are frequent
    task automatic queue_refs(int count, logic [PG_W-1:0] base, int span);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 85)
                page_q.push_back(base + PG_W'($urandom_range(span)));
            else
                page_q.push_back(PG_W'($urandom));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] settings[10];
        logic [PG_W-1:0]  base;
        int span;

        settings = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd15, 4'd9, 4'd1};
        send_idle_pct = 25;
        recv_idle_pct = 59;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset frame count of eight, fill all frames, hit, evict
        page_q = '{16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h0001, 16'h0002,
                   16'h0003, 16'h0004, 16'hFFFF, 16'h1234, 16'hAAAA, 16'h0000};
        wait_drained();
        // one frame: every new page evicts the previous one
        write_frames(4'd1);
        page_q = '{16'h0007, 16'h0007, 16'h0008, 16'h0007};
        wait_drained();
        // zero frames acts as one
        write_frames(4'd0);
        page_q = '{16'h0009, 16'h0009, 16'hFFFF};
        wait_drained();
        // above the maximum acts as the maximum
        write_frames(4'd15);
        page_q = '{16'h8000, 16'h8000, 16'h0001, 16'h7FFF};
        wait_drained();

        // random phases, one frame count each
        for (int p = 0; p < 10; p++) begin
            if (p == 4) begin
                send_idle_pct = 59;
                recv_idle_pct = 25;
            end else if (p == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_frames(settings[p]);
            base = PG_W'($urandom);
            span = active_frames(settings[p]) + 2;
            queue_refs(23, base, span);
            if (p == 7) begin
                // receiver holds off while references keep coming
                @(posedge i_clk);
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            wait_drained();
            queue_refs(22, base, span);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        $display("Checked %0d results: %0d hits, %0d evictions, %0d fills of empty frames,",
                 n_checked, n_hits, n_evicts, n_fills);
        $display("over %0d frame count writes including 0, 1, 8 and values above 8.", n_cfg);
        if (n_errors == 0 && result_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
design/lrupr_pkg.sv
design/lrupr_ram.sv
design/lrupr_rank.sv
design/lru_page_replacement.sv
tb/tb_lru_page_replacement.sv
